// ===== hdl/led_bank_shift_driver_top_assert.svh =====
// Assertion macros for the LED bank shift driver
`ifndef LED_BANK_SHIFT_DRIVER_TOP_ASSERT_SVH
`define LED_BANK_SHIFT_DRIVER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LBSD_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("lbsd assertion failed");

// antecedent implies consequent in the next cycle
`define LBSD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("lbsd assertion failed");

`endif

// ===== hdl/lbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsd_pkg
// Shared types, constants and command decode for the LED bank shift driver.
// ----------------------------------------------------------------------------
package lbsd_pkg;

  localparam int NUM_GROUPS_DEF = 16;
  localparam int TIMER_BITS_DEF = 16;

  localparam int BYTE_W   = 8;
  localparam int GRP_W    = 4;
  localparam int CMD_W    = 8;
  localparam int TIMER_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd20;
  localparam logic [APB_AW-1:0]   REG_BLINK_PERIOD = 2'd0;

  localparam logic [CMD_W-1:0] CMD_NONE      = 8'd0;
  localparam logic [CMD_W-1:0] CMD_LIGHT_LO  = 8'd1;
  localparam logic [CMD_W-1:0] CMD_LIGHT_HI  = 8'd128;
  localparam logic [CMD_W-1:0] CMD_CLEAR_LO  = 8'd129;
  localparam logic [CMD_W-1:0] CMD_CLEAR_HI  = 8'd240;
  localparam logic [CMD_W-1:0] CMD_SETM_LO   = 8'd241;
  localparam logic [CMD_W-1:0] CMD_SETM_HI   = 8'd248;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 8'd255;

  localparam logic [BYTE_W-1:0] LED_MSB = 8'h80;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_LIGHT,
    CK_CLEAR,
    CK_SET_MASKED,
    CK_REFRESH,
    CK_CLEAR_ALL
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_TEST,
    ST_SEND_CMD,
    ST_TOGGLE,
    ST_SEND_BLINK
  } state_t;

  typedef struct packed {
    logic take_check;
    logic take_mask;
    logic apply;
    logic test;
    logic toggle;
    logic emit;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_none;
    logic hit_now;
    logic hit;
    logic cnt_zero;
    logic out_free;
  } dp_sts_t;

  function automatic cmd_kind_t cmd_decode(input logic [CMD_W-1:0] c);
    cmd_kind_t k;
    if (c == CMD_NONE) begin
      k = CK_NONE;
    end else if (c inside {[CMD_LIGHT_LO:CMD_LIGHT_HI]}) begin
      k = CK_LIGHT;
    end else if (c inside {[CMD_CLEAR_LO:CMD_CLEAR_HI]}) begin
      k = CK_CLEAR;
    end else if (c inside {[CMD_SETM_LO:CMD_SETM_HI]}) begin
      k = CK_SET_MASKED;
    end else if (c == CMD_CLEAR_ALL) begin
      k = CK_CLEAR_ALL;
    end else begin
      k = CK_REFRESH;
    end
    return k;
  endfunction

endpackage

// ===== hdl/led_bank_shift_driver_top.sv =====
// ----------------------------------------------------------------------------
// led_bank_shift_driver_top: LED image and blink mask with serial chain output
// A check applies its command, tests the blink timer, sends the image unless the command
// is none, and on a hit toggles and resends it; words go one per cycle unless the chain stalls.
// Reset clears image, mask, blink timing and control; period resets to 20.
// ----------------------------------------------------------------------------
`include "led_bank_shift_driver_top_assert.svh"

module led_bank_shift_driver_top import lbsd_pkg::*; #(
  parameter int NUM_GROUPS = NUM_GROUPS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [CMD_W-1:0]    in_led_id,
  input  logic [TIMER_W-1:0]  in_timer_value,
  input  logic [GRP_W-1:0]    in_mask_group,
  input  logic [BYTE_W-1:0]   in_mask_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_shift_byte,
  output logic [GRP_W-1:0]    out_group_index,
  output logic                out_latch,
  output logic                out_last
);

  logic [PERIOD_W-1:0] blink_period;
  dp_cmd_t             dp_cmd;
  dp_sts_t             dp_sts;

  lbsd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .blink_period (blink_period)
  );

  lbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  lbsd_dp #(
    .NUM_GROUPS (NUM_GROUPS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_led_id       (in_led_id),
    .in_timer_value  (in_timer_value),
    .in_mask_group   (in_mask_group),
    .in_mask_byte    (in_mask_byte),
    .blink_period    (blink_period),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_shift_byte  (out_shift_byte),
    .out_group_index (out_group_index),
    .out_latch       (out_latch),
    .out_last        (out_last)
  );

  `LBSD_ASSERT_NEXT(a_check_busy, clk, rst_n, in_valid && !in_stall && !in_func, in_stall)
  `LBSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_shift_byte))
  `LBSD_ASSERT_NOW(a_last_latch, clk, rst_n, out_valid && out_last, out_latch)

endmodule

// ===== hdl/lbsd_regs.sv =====
// ----------------------------------------------------------------------------
// lbsd_regs
// APB register block holding the blink period.
// ----------------------------------------------------------------------------
module lbsd_regs import lbsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [PERIOD_W-1:0] blink_period
);

  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] period_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_BLINK_PERIOD);

  always_comb begin
    period_nxt = period_r;
    if (wr_en) begin
      period_nxt = pwdata[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else begin
      period_r <= period_nxt;
    end
  end

  assign prdata       = (paddr == REG_BLINK_PERIOD) ? APB_DW'(period_r) : '0;
  assign blink_period = period_r;

endmodule

// ===== hdl/lbsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbsd_ctrl
// Sequencer: command, blink test, image sends and blink toggle.
// ----------------------------------------------------------------------------
module lbsd_ctrl import lbsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_func,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_func) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (!sts.cmd_none) begin
          state_nxt = ST_SEND_CMD;
        end else if (sts.hit_now) begin
          state_nxt = ST_TOGGLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND_CMD: begin
        if (sts.out_free && sts.cnt_zero) begin
          state_nxt = sts.hit ? ST_TOGGLE : ST_IDLE;
        end
      end
      ST_TOGGLE: begin
        state_nxt = ST_SEND_BLINK;
      end
      ST_SEND_BLINK: begin
        if (sts.out_free && sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.take_check = in_valid && !in_func;
        cmd.take_mask  = in_valid && in_func;
      end
      ST_CMD: begin
        cmd.apply = 1'b1;
      end
      ST_TEST: begin
        cmd.test = 1'b1;
      end
      ST_SEND_CMD: begin
        cmd.emit      = sts.out_free;
        cmd.emit_last = !sts.hit;
      end
      ST_TOGGLE: begin
        cmd.toggle = 1'b1;
      end
      ST_SEND_BLINK: begin
        cmd.emit      = sts.out_free;
        cmd.emit_last = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lbsd_dp.sv =====
// ----------------------------------------------------------------------------
// lbsd_dp
// Image and mask registers, blink timing and the output word register.
// ----------------------------------------------------------------------------
module lbsd_dp import lbsd_pkg::*; #(
  parameter int NUM_GROUPS = NUM_GROUPS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CMD_W-1:0]    in_led_id,
  input  logic [TIMER_W-1:0]  in_timer_value,
  input  logic [GRP_W-1:0]    in_mask_group,
  input  logic [BYTE_W-1:0]   in_mask_byte,
  input  logic [PERIOD_W-1:0] blink_period,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_shift_byte,
  output logic [GRP_W-1:0]    out_group_index,
  output logic                out_latch,
  output logic                out_last
);

  localparam int CW   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int TEXT = (TIMER_BITS > TIMER_W) ? TIMER_BITS : TIMER_W;
  localparam logic [CW-1:0] CNT_TOP = CW'(NUM_GROUPS - 1);

  logic [BYTE_W-1:0]     img_r   [NUM_GROUPS];
  logic [BYTE_W-1:0]     img_nxt [NUM_GROUPS];
  logic [BYTE_W-1:0]     mask_r  [NUM_GROUPS];
  logic [BYTE_W-1:0]     mask_nxt[NUM_GROUPS];
  logic [CMD_W-1:0]      led_r;
  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] due_r;
  logic [TIMER_BITS-1:0] due_nxt;
  logic                  phase_r;
  logic                  phase_nxt;
  logic                  hit_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_byte_r;
  logic [GRP_W-1:0]      out_grp_r;
  logic                  out_latch_r;
  logic                  out_last_r;

  logic [TEXT-1:0]       timer_ext;
  logic [TEXT-1:0]       period_ext;
  logic [TIMER_BITS-1:0] period_t;
  cmd_kind_t             kind;
  logic [CMD_W-1:0]      led_m1;
  logic [GRP_W-1:0]      light_grp;
  logic [BYTE_W-1:0]     light_bit;
  logic                  mask_any;
  logic                  hit_now;
  logic                  cnt_zero;
  logic                  out_free;

  assign timer_ext  = TEXT'(in_timer_value);
  assign period_ext = TEXT'(blink_period);
  assign period_t   = period_ext[TIMER_BITS-1:0];

  assign kind      = cmd_decode(led_r);
  assign led_m1    = led_r - CMD_LIGHT_LO;
  assign light_grp = led_m1[6:3];
  assign light_bit = LED_MSB >> led_m1[2:0];

  always_comb begin
    mask_any = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mask_any = mask_any | (|mask_r[g]);
    end
  end

  assign hit_now  = mask_any && (due_r == timer_r);
  assign cnt_zero = (cnt_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    img_nxt   = img_r;
    mask_nxt  = mask_r;
    due_nxt   = due_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (cmd.take_mask) begin
      if (32'(in_mask_group) < NUM_GROUPS) begin
        mask_nxt[CW'(in_mask_group)] = in_mask_byte;
      end
    end else if (cmd.apply) begin
      case (kind)
        CK_LIGHT: begin
          if (32'(light_grp) < NUM_GROUPS) begin
            img_nxt[CW'(light_grp)] = img_r[CW'(light_grp)] | light_bit;
          end
        end
        CK_CLEAR: begin
          img_nxt = '{default: '0};
        end
        CK_SET_MASKED: begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            img_nxt[g] = img_r[g] | mask_r[g];
          end
        end
        CK_CLEAR_ALL: begin
          img_nxt  = '{default: '0};
          mask_nxt = '{default: '0};
        end
        default: begin
          img_nxt = img_r;
        end
      endcase
    end else if (cmd.toggle) begin
      due_nxt   = timer_r + period_t;
      phase_nxt = !phase_r;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        img_nxt[g] = phase_r ? (img_r[g] | mask_r[g]) : (img_r[g] & ~mask_r[g]);
      end
    end else if (cmd.emit) begin
      img_nxt[0] = img_r[NUM_GROUPS-1];
      for (int g = 1; g < NUM_GROUPS; g++) begin
        img_nxt[g] = img_r[g-1];
      end
      cnt_nxt = cnt_zero ? CNT_TOP : (cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r       <= '{default: '0};
      mask_r      <= '{default: '0};
      due_r       <= '0;
      phase_r     <= 1'b0;
      hit_r       <= 1'b0;
      cnt_r       <= CNT_TOP;
      out_valid_r <= 1'b0;
    end else begin
      img_r   <= img_nxt;
      mask_r  <= mask_nxt;
      due_r   <= due_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.test) begin
        hit_r <= hit_now;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_check) begin
      led_r   <= in_led_id;
      timer_r <= timer_ext[TIMER_BITS-1:0];
    end
    if (cmd.emit) begin
      out_byte_r  <= img_r[NUM_GROUPS-1];
      out_grp_r   <= GRP_W'(cnt_r);
      out_latch_r <= cnt_zero;
      out_last_r  <= cnt_zero && cmd.emit_last;
    end
  end

  assign sts.cmd_none = (kind == CK_NONE);
  assign sts.hit_now  = hit_now;
  assign sts.hit      = hit_r;
  assign sts.cnt_zero = cnt_zero;
  assign sts.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_shift_byte  = out_byte_r;
  assign out_group_index = out_grp_r;
  assign out_latch       = out_latch_r;
  assign out_last        = out_last_r;

endmodule

// ===== tb/sv/led_bank_shift_driver_checker.sv =====
// ----------------------------------------------------------------------------
// led_bank_shift_driver_checker
// Snoops the config port and both word channels of the LED bank shift driver.
// Each accepted input word runs through a local model of the LED image, the
// blink mask and the blink timing. The model queues the chain words that the
// word should cause. Every output word is checked against the oldest queued
// one. The checker reports its failure count and backlog to the top, and also
// the current blink due time, which the stimulus uses to hit blink toggles.
// ----------------------------------------------------------------------------
module led_bank_shift_driver_checker import lbsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_func,
  input  logic [CMD_W-1:0]    in_led_id,
  input  logic [TIMER_W-1:0]  in_timer_value,
  input  logic [GRP_W-1:0]    in_mask_group,
  input  logic [BYTE_W-1:0]   in_mask_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [BYTE_W-1:0]   out_shift_byte,
  input  logic [GRP_W-1:0]    out_group_index,
  input  logic                out_latch,
  input  logic                out_last,
  output int                  fail_count,
  output int                  chain_backlog,
  output int                  in_words,
  output int                  out_words,
  output logic [TIMER_W-1:0]  blink_due_now
);

  localparam int NG = NUM_GROUPS_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] shift_byte;
    logic [GRP_W-1:0]  group_index;
    logic              latch;
    logic              last;
  } chain_word_t;

  logic [BYTE_W-1:0]   led_image  [NG];
  logic [BYTE_W-1:0]   blink_mask [NG];
  logic [TIMER_W-1:0]  blink_due;
  logic                blink_phase;
  logic [PERIOD_W-1:0] blink_period;

  chain_word_t expected_chain [$];
  chain_word_t burst [$];

  assign blink_due_now = blink_due;

  task automatic queue_image_dump();
    chain_word_t w;
    for (int g = NG - 1; g >= 0; g--) begin
      w.shift_byte  = led_image[g];
      w.group_index = g[GRP_W-1:0];
      w.latch       = (g == 0);
      w.last        = 1'b0;
      burst.push_back(w);
    end
  endtask

  task automatic apply_led_command(input logic [CMD_W-1:0] cmd);
    logic [CMD_W-1:0] pos;
    if (cmd >= CMD_LIGHT_LO && cmd <= CMD_LIGHT_HI) begin
      pos = cmd - 8'd1;
      led_image[pos[6:3]] = led_image[pos[6:3]] | (LED_MSB >> pos[2:0]);
    end else if (cmd >= CMD_CLEAR_LO && cmd <= CMD_CLEAR_HI) begin
      for (int g = 0; g < NG; g++) led_image[g] = '0;
    end else if (cmd >= CMD_SETM_LO && cmd <= CMD_SETM_HI) begin
      for (int g = 0; g < NG; g++) led_image[g] = led_image[g] | blink_mask[g];
    end else if (cmd == CMD_CLEAR_ALL) begin
      for (int g = 0; g < NG; g++) begin
        led_image[g]  = '0;
        blink_mask[g] = '0;
      end
    end
  endtask

  task automatic predict_check(input logic [CMD_W-1:0] cmd, input logic [TIMER_W-1:0] timer);
    chain_word_t w;
    logic        any_mask;
    int          idx;
    burst.delete();
    if (cmd != CMD_NONE) begin
      apply_led_command(cmd);
      queue_image_dump();
    end
    any_mask = 1'b0;
    for (int g = 0; g < NG; g++) any_mask = any_mask | (blink_mask[g] != '0);
    if (any_mask && blink_due == timer) begin
      blink_due = timer + blink_period;
      for (int g = 0; g < NG; g++) begin
        if (blink_phase) begin
          led_image[g] = led_image[g] | blink_mask[g];
        end else begin
          led_image[g] = led_image[g] & ~blink_mask[g];
        end
      end
      blink_phase = ~blink_phase;
      queue_image_dump();
    end
    if (burst.size() > 0) begin
      idx        = burst.size() - 1;
      w          = burst[idx];
      w.last     = 1'b1;
      burst[idx] = w;
    end
    foreach (burst[i]) expected_chain.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    chain_word_t got;
    chain_word_t exp_w;
    if (!rst_n) begin
      for (int g = 0; g < NG; g++) begin
        led_image[g]  = '0;
        blink_mask[g] = '0;
      end
      blink_due    = '0;
      blink_phase  = 1'b0;
      blink_period = PERIOD_RESET;
      expected_chain.delete();
      fail_count   = 0;
      in_words     = 0;
      out_words    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_BLINK_PERIOD) begin
        blink_period = pwdata[PERIOD_W-1:0];
      end
      if (out_valid && !out_stall) begin
        out_words++;
        got = '{out_shift_byte, out_group_index, out_latch, out_last};
        if (expected_chain.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected chain word: expected none, actual byte %h group %0d latch %b last %b",
                   $time, got.shift_byte, got.group_index, got.latch, got.last);
        end else begin
          exp_w = expected_chain.pop_front();
          if (got !== exp_w) begin
            fail_count++;
            $display("%0t: chain word mismatch: expected byte %h group %0d latch %b last %b, actual byte %h group %0d latch %b last %b",
                     $time, exp_w.shift_byte, exp_w.group_index, exp_w.latch, exp_w.last,
                     got.shift_byte, got.group_index, got.latch, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_words++;
        if (in_func) begin
          blink_mask[in_mask_group] = in_mask_byte;
        end else begin
          predict_check(in_led_id, in_timer_value);
        end
      end
    end
    chain_backlog = expected_chain.size();
  end

endmodule

// ===== tb/sv/led_bank_shift_driver_top_tb.sv =====
// ----------------------------------------------------------------------------
// led_bank_shift_driver_top_tb
// Drives the LED bank shift driver with a directed run of commands, mask
// writes and blink hits, then random phases at several blink periods with
// random gaps on the input and random stalls on the chain output, both off
// in the zero-period phase. A checker beside the block predicts and compares
// every chain word. The top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module led_bank_shift_driver_top_tb;
  import lbsd_pkg::*;

  localparam int SETTLE_CYCLES  = 2 * NUM_GROUPS_DEF + 12;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASE_WORDS    = 38;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                in_func        = 1'b0;
  logic [CMD_W-1:0]    in_led_id      = '0;
  logic [TIMER_W-1:0]  in_timer_value = '0;
  logic [GRP_W-1:0]    in_mask_group  = '0;
  logic [BYTE_W-1:0]   in_mask_byte   = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [BYTE_W-1:0]   out_shift_byte;
  logic [GRP_W-1:0]    out_group_index;
  logic                out_latch;
  logic                out_last;

  int                  fail_count;
  int                  chain_backlog;
  int                  in_words;
  int                  out_words;
  logic [TIMER_W-1:0]  blink_due_now;

  bit                  stall_on  = 1'b1;
  bit                  gaps_on   = 1'b1;
  int                  stall_hold = 0;
  int                  stall_pick;
  int                  idle_cycles = 0;
  int                  seen_in     = 0;
  int                  seen_out    = 0;

  led_bank_shift_driver_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_led_id       (in_led_id),
    .in_timer_value  (in_timer_value),
    .in_mask_group   (in_mask_group),
    .in_mask_byte    (in_mask_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_shift_byte  (out_shift_byte),
    .out_group_index (out_group_index),
    .out_latch       (out_latch),
    .out_last        (out_last)
  );

  led_bank_shift_driver_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_led_id       (in_led_id),
    .in_timer_value  (in_timer_value),
    .in_mask_group   (in_mask_group),
    .in_mask_byte    (in_mask_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_shift_byte  (out_shift_byte),
    .out_group_index (out_group_index),
    .out_latch       (out_latch),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .chain_backlog   (chain_backlog),
    .in_words        (in_words),
    .out_words       (out_words),
    .blink_due_now   (blink_due_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // chain side stalls: mostly short, a few long, none while stall_on is low
  always @(negedge clk) begin
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(1, 12);
      end else if (stall_pick < 85) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(3, 9);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(20, 60);
      end
    end
  end

  always @(negedge clk) begin
    if (in_words != seen_in || out_words != seen_out) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    seen_in  = in_words;
    seen_out = out_words;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("led_bank_shift_driver_top_tb: FAIL");
      $finish;
    end
  end

  task automatic drive_word(input logic func, input logic [CMD_W-1:0] led,
                            input logic [TIMER_W-1:0] timer, input logic [GRP_W-1:0] grp,
                            input logic [BYTE_W-1:0] mbyte);
    int target;
    target = in_words + 1;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_led_id      <= led;
    in_timer_value <= timer;
    in_mask_group  <= grp;
    in_mask_byte   <= mbyte;
    do @(negedge clk); while (in_words != target);
  endtask

  task automatic send_check(input logic [CMD_W-1:0] led, input logic [TIMER_W-1:0] timer);
    drive_word(1'b0, led, timer, GRP_W'($urandom_range(0, 15)),
               BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_mask(input logic [GRP_W-1:0] grp, input logic [BYTE_W-1:0] mbyte);
    drive_word(1'b1, CMD_W'($urandom_range(0, 255)), TIMER_W'($urandom_range(0, 65535)),
               grp, mbyte);
  endtask

  task automatic sender_pause();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 55) n = 0;
    else if (pick < 87) n = $urandom_range(1, 3);
    else if (pick < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(30, 80);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_chain();
    in_valid <= 1'b0;
    while (chain_backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLINK_PERIOD;
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_led();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CMD_NONE;
    if (r < 55) return CMD_W'($urandom_range(CMD_LIGHT_LO, CMD_LIGHT_HI));
    if (r < 65) return CMD_W'($urandom_range(CMD_CLEAR_LO, CMD_CLEAR_HI));
    if (r < 75) return CMD_W'($urandom_range(CMD_SETM_LO, CMD_SETM_HI));
    if (r < 85) return CMD_W'($urandom_range(CMD_SETM_HI + 1, CMD_CLEAR_ALL - 1));
    if (r < 88) return CMD_CLEAR_ALL;
    return CMD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIMER_W-1:0] pick_timer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return blink_due_now;
    if (r < 50) return blink_due_now + 16'd1;
    if (r < 55) return blink_due_now - 16'd1;
    return TIMER_W'($urandom_range(0, 65535));
  endfunction

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        send_mask(GRP_W'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else begin
        send_check(pick_led(), pick_timer());
      end
      sender_pause();
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] periods [5];
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_check(CMD_NONE, 16'd0);
    send_check(CMD_LIGHT_LO, 16'd5);
    sender_pause();
    send_check(CMD_LIGHT_HI, 16'hffff);
    send_check(8'd64, 16'd7);
    send_mask(4'd0, 8'hff);
    sender_pause();
    send_mask(4'd15, 8'h81);
    send_mask(4'd7, 8'h5a);
    send_check(CMD_NONE, blink_due_now);
    sender_pause();
    send_check(8'd249, blink_due_now);
    send_check(CMD_SETM_LO, 16'd1);
    send_check(CMD_CLEAR_LO, 16'd2);
    sender_pause();
    send_check(CMD_CLEAR_HI, blink_due_now);
    send_check(CMD_SETM_HI, blink_due_now);
    send_check(8'd254, 16'd3);
    sender_pause();
    send_check(CMD_CLEAR_ALL, 16'd9);
    send_check(CMD_NONE, blink_due_now);
    send_mask(4'd3, 8'h01);
    send_mask(4'd3, 8'h00);
    send_mask(4'd9, 8'h10);
    send_check(CMD_NONE, blink_due_now);
    send_check(8'd73, blink_due_now);

    periods[0] = 16'd1;
    periods[1] = 16'hffff;
    periods[2] = 16'd0;
    periods[3] = PERIOD_W'($urandom_range(2, 65534));
    periods[4] = PERIOD_RESET;
    for (int p = 0; p < 5; p++) begin
      drain_chain();
      write_period(periods[p]);
      stall_on = (p != 2);
      gaps_on  = (p != 2);
      run_phase(PHASE_WORDS);
    end
    stall_on = 1'b1;
    gaps_on  = 1'b1;

    drain_chain();
    if (fail_count == 0 && chain_backlog == 0) begin
      $display("led_bank_shift_driver_top_tb: PASS");
    end else begin
      $display("led_bank_shift_driver_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lbsd_pkg.sv
hdl/lbsd_regs.sv
hdl/lbsd_ctrl.sv
hdl/lbsd_dp.sv
hdl/led_bank_shift_driver_top.sv
tb/sv/led_bank_shift_driver_checker.sv
tb/sv/led_bank_shift_driver_top_tb.sv
